@@ design/nnkc_pkg.sv @@
// Shared widths, register indexes and stage types of the nearest node search.
`default_nettype none

package nnkc_pkg;

   localparam int CoordW     = 16;
   localparam int DistW      = 34;
   localparam int IdxW       = 10;
   localparam int SqW        = 2 * CoordW;
   localparam int CsrIdxW    = 1;
   localparam int MaxNodesDefault = 1024;

   localparam logic [CsrIdxW-1:0] CSR_KILL_DIST_SQ    = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_ATTRACT_DIST_SQ = 1'b1;

   typedef struct packed {
      logic             valid;
      logic             last;
      logic [DistW-1:0] dist_sq;
      logic             kill_hit;
      logic             attract_hit;
   } dist_type;

endpackage

`default_nettype wire

@@ design/nnkc_dist.sv @@
// Input register, per-axis squares and squared distance with threshold compares.
`default_nettype none

module nnkc_dist (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          in_valid,
   input  wire logic [nnkc_pkg::CoordW-1:0]   point_x,
   input  wire logic [nnkc_pkg::CoordW-1:0]   point_y,
   input  wire logic [nnkc_pkg::CoordW-1:0]   point_z,
   input  wire logic [nnkc_pkg::CoordW-1:0]   node_x,
   input  wire logic [nnkc_pkg::CoordW-1:0]   node_y,
   input  wire logic [nnkc_pkg::CoordW-1:0]   node_z,
   input  wire logic                          node_last,
   input  wire logic [nnkc_pkg::DistW-1:0]    kill_dist_sq,
   input  wire logic [nnkc_pkg::DistW-1:0]    attract_dist_sq,
   output nnkc_pkg::dist_type                 dist_out
);
   import nnkc_pkg::*;

   function automatic logic [CoordW-1:0] abs_diff(input logic [CoordW-1:0] a,
                                                  input logic [CoordW-1:0] b);
      logic [CoordW:0] d;
      logic [CoordW:0] n;
      d = {a[CoordW-1], a} - {b[CoordW-1], b};
      n = -d;
      return d[CoordW] ? n[CoordW-1:0] : d[CoordW-1:0];
   endfunction

   // stage 1: input register
   logic              s1_valid_ff;
   logic              s1_last_ff;
   logic [CoordW-1:0] px_ff, py_ff, pz_ff, nx_ff, ny_ff, nz_ff;

   // stage 2: squares
   logic              s2_valid_ff;
   logic              s2_last_ff;
   logic [SqW-1:0]    sq_x_ff, sq_y_ff, sq_z_ff;
   logic [CoordW-1:0] ax, ay, az;
   logic [SqW-1:0]    sq_x_in, sq_y_in, sq_z_in;

   // stage 3: distance and compares
   dist_type          s3_ff;
   dist_type          s3_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s1_last_ff  <= node_last;
         px_ff       <= point_x;
         py_ff       <= point_y;
         pz_ff       <= point_z;
         nx_ff       <= node_x;
         ny_ff       <= node_y;
         nz_ff       <= node_z;
         s2_last_ff  <= s1_last_ff;
         sq_x_ff     <= sq_x_in;
         sq_y_ff     <= sq_y_in;
         sq_z_ff     <= sq_z_in;
         s3_ff       <= s3_in;
      end
   end

   always_comb begin
      ax      = abs_diff(nx_ff, px_ff);
      ay      = abs_diff(ny_ff, py_ff);
      az      = abs_diff(nz_ff, pz_ff);
      sq_x_in = SqW'(ax) * SqW'(ax);
      sq_y_in = SqW'(ay) * SqW'(ay);
      sq_z_in = SqW'(az) * SqW'(az);
   end

   always_comb begin
      s3_in.valid       = s2_valid_ff;
      s3_in.last        = s2_last_ff;
      s3_in.dist_sq     = DistW'(sq_x_ff) + DistW'(sq_y_ff) + DistW'(sq_z_ff);
      s3_in.kill_hit    = s3_in.dist_sq <= kill_dist_sq;
      s3_in.attract_hit = s3_in.dist_sq <= attract_dist_sq;
   end

   assign dist_out = s3_ff;

endmodule

`default_nettype wire

@@ design/nnkc_track.sv @@
// Running nearest node, kill flag, node counter and result register.
`default_nettype none

module nnkc_track #(
   parameter int MAX_NODES = nnkc_pkg::MaxNodesDefault
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire nnkc_pkg::dist_type          dist_in,
   output logic                             rsp_valid,
   output logic [nnkc_pkg::IdxW-1:0]        rsp_closest_index,
   output logic [nnkc_pkg::DistW-1:0]      rsp_closest_dist_sq,
   output logic                             rsp_attracted,
   output logic                             rsp_killed
);
   import nnkc_pkg::*;

   localparam int CntW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
   localparam logic [CntW-1:0] MaxIdx = CntW'(MAX_NODES - 1);

   logic [CntW-1:0]  count_ff, count_in;
   logic [DistW-1:0] best_dist_ff, best_dist_in;
   logic [CntW-1:0]  best_idx_ff, best_idx_in;
   logic             best_attr_ff, best_attr_in;
   logic             kill_ff, kill_in;
   logic             take;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [IdxW-1:0]  rsp_idx_ff;
   logic [DistW-1:0] rsp_dist_ff;
   logic             rsp_attr_ff;
   logic             rsp_kill_ff;

   always_comb begin
      take         = (count_ff == '0) || (dist_in.dist_sq < best_dist_ff);
      best_dist_in = take ? dist_in.dist_sq     : best_dist_ff;
      best_idx_in  = take ? count_ff            : best_idx_ff;
      best_attr_in = take ? dist_in.attract_hit : best_attr_ff;
      kill_in      = ((count_ff != '0) && kill_ff) || dist_in.kill_hit;
      count_in     = (count_ff < MaxIdx) ? count_ff + 1'b1 : count_ff;
      rsp_valid_in = dist_in.valid && dist_in.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         kill_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
         if (dist_in.valid) begin
            kill_ff  <= kill_in;
            count_ff <= dist_in.last ? '0 : count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && dist_in.valid) begin
         best_dist_ff <= best_dist_in;
         best_idx_ff  <= best_idx_in;
         best_attr_ff <= best_attr_in;
         if (dist_in.last) begin
            rsp_idx_ff  <= IdxW'(best_idx_in);
            rsp_dist_ff <= best_dist_in;
            rsp_attr_ff <= best_attr_in;
            rsp_kill_ff <= kill_in;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_closest_index   = rsp_idx_ff;
   assign rsp_closest_dist_sq = rsp_dist_ff;
   assign rsp_attracted       = rsp_attr_ff;
   assign rsp_killed          = rsp_kill_ff;

endmodule

`default_nettype wire

@@ design/nearest_node_with_kill_check_unit.sv @@
// Top level of the nearest node search with kill check.
//
// Usage: each req_ transaction carries one attraction point and one node; the
// nodes of one list arrive in order and the last carries req_node_last. One
// rsp_ transaction follows each list: nearest node index (first on ties, held
// at MAX_NODES-1 for later positions), its squared distance, the attracted
// flag and the killed flag.
// Throughput: one node per cycle while the pipeline is not stalled, set by the
// four-register pipeline (input, squares, distance sum with compares, result)
// that moves as one; a result appears on rsp_ once the last node has passed all four.
// Stall: while rsp_valid is high and rsp_stall is high the whole pipeline holds
// and req_stall is high; otherwise req_stall is low.
// Configuration: csr_ transactions write the kill threshold (index 0) and the
// attraction threshold (index 1); csr_ready is always high. Write only while
// no list is in flight.
// Reset: synchronous; clears both thresholds, the pipeline and the list state.
`default_nettype none

module nearest_node_with_kill_check_unit #(
   parameter int MAX_NODES = nnkc_pkg::MaxNodesDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [nnkc_pkg::CoordW-1:0]   req_point_x,
   input  wire logic [nnkc_pkg::CoordW-1:0]   req_point_y,
   input  wire logic [nnkc_pkg::CoordW-1:0]   req_point_z,
   input  wire logic [nnkc_pkg::CoordW-1:0]   req_node_x,
   input  wire logic [nnkc_pkg::CoordW-1:0]   req_node_y,
   input  wire logic [nnkc_pkg::CoordW-1:0]   req_node_z,
   input  wire logic                          req_node_last,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [nnkc_pkg::IdxW-1:0]          rsp_closest_index,
   output logic [nnkc_pkg::DistW-1:0]         rsp_closest_dist_sq,
   output logic                               rsp_attracted,
   output logic                               rsp_killed,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [nnkc_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [nnkc_pkg::DistW-1:0]    csr_data
);
   import nnkc_pkg::*;

   logic [DistW-1:0] kill_dist_sq_ff;
   logic [DistW-1:0] attract_dist_sq_ff;
   logic             advance;
   dist_type         dist_stage;

   assign csr_ready = 1'b1;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         kill_dist_sq_ff    <= '0;
         attract_dist_sq_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KILL_DIST_SQ:    kill_dist_sq_ff    <= csr_data;
            CSR_ATTRACT_DIST_SQ: attract_dist_sq_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   nnkc_dist u_dist (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .in_valid        (req_valid),
      .point_x         (req_point_x),
      .point_y         (req_point_y),
      .point_z         (req_point_z),
      .node_x          (req_node_x),
      .node_y          (req_node_y),
      .node_z          (req_node_z),
      .node_last       (req_node_last),
      .kill_dist_sq    (kill_dist_sq_ff),
      .attract_dist_sq (attract_dist_sq_ff),
      .dist_out        (dist_stage)
   );

   nnkc_track #(
      .MAX_NODES (MAX_NODES)
   ) u_track (
      .clock               (clock),
      .reset               (reset),
      .advance             (advance),
      .dist_in             (dist_stage),
      .rsp_valid           (rsp_valid),
      .rsp_closest_index   (rsp_closest_index),
      .rsp_closest_dist_sq (rsp_closest_dist_sq),
      .rsp_attracted       (rsp_attracted),
      .rsp_killed          (rsp_killed)
   );

`ifndef SYNTH
   a_stall_backs_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while result is stalled");

   a_attract_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_attracted == (rsp_closest_dist_sq <= attract_dist_sq_ff))
      else $error("attracted flag disagrees with distance");

   a_kill_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_closest_dist_sq <= kill_dist_sq_ff) |-> rsp_killed)
      else $error("nearest node within kill distance but not killed");
`endif

endmodule

`default_nettype wire

@@ bench/tb_nearest_node_with_kill_check_unit.sv @@
// Self-checking testbench for the nearest node search with kill check.
`default_nettype none

module tb_nearest_node_with_kill_check_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import nnkc_pkg::*;

   localparam int MaxNodes = MaxNodesDefault;
   localparam longint unsigned DistMax = 64'd12884508675;

   typedef struct {
      logic signed [CoordW-1:0] px, py, pz;
      logic signed [CoordW-1:0] nx, ny, nz;
      logic                     last;
   } node_item_type;

   typedef struct {
      logic [IdxW-1:0]  index;
      logic [DistW-1:0] dist_sq;
      logic             attracted;
      logic             killed;
   } nearest_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CoordW-1:0]   req_point_x = '0;
   logic [CoordW-1:0]   req_point_y = '0;
   logic [CoordW-1:0]   req_point_z = '0;
   logic [CoordW-1:0]   req_node_x = '0;
   logic [CoordW-1:0]   req_node_y = '0;
   logic [CoordW-1:0]   req_node_z = '0;
   logic                req_node_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [IdxW-1:0]     rsp_closest_index;
   logic [DistW-1:0]    rsp_closest_dist_sq;
   logic                rsp_attracted;
   logic                rsp_killed;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index = CSR_KILL_DIST_SQ;
   logic [DistW-1:0]    csr_data = '0;

   // search state mirrored from the block
   logic [DistW-1:0] kill_thr = '0;
   logic [DistW-1:0] attract_thr = '0;
   logic [DistW-1:0] best_dist = '0;
   logic [IdxW-1:0]  best_index = '0;
   int unsigned      list_pos = 0;
   bit               kill_seen = 1'b0;

   node_item_type  node_backlog[$];
   nearest_type    nearest_due[$];
   node_item_type  on_bus;
   int unsigned req_gap = 0;
   int unsigned rsp_hold = 0;
   bit          calm = 1'b0;
   int unsigned mismatches = 0;

   nearest_node_with_kill_check_unit #(
      .MAX_NODES(MaxNodes)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_point_x         (req_point_x),
      .req_point_y         (req_point_y),
      .req_point_z         (req_point_z),
      .req_node_x          (req_node_x),
      .req_node_y          (req_node_y),
      .req_node_z          (req_node_z),
      .req_node_last       (req_node_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_closest_index   (rsp_closest_index),
      .rsp_closest_dist_sq (rsp_closest_dist_sq),
      .rsp_attracted       (rsp_attracted),
      .rsp_killed          (rsp_killed),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [DistW-1:0] sq_dist(input node_item_type it);
      longint dx, dy, dz;
      dx = longint'(it.nx) - longint'(it.px);
      dy = longint'(it.ny) - longint'(it.py);
      dz = longint'(it.nz) - longint'(it.pz);
      return DistW'(dx * dx + dy * dy + dz * dz);
   endfunction

   task automatic track_node(input node_item_type it);
      logic [DistW-1:0] d;
      nearest_type      r;
      d = sq_dist(it);
      if (list_pos == 0 || d < best_dist) begin
         best_dist = d;
         best_index = IdxW'(list_pos);
      end
      if (d <= kill_thr) kill_seen = 1'b1;
      if (list_pos < MaxNodes - 1) list_pos++;
      if (it.last) begin
         r.index = best_index;
         r.dist_sq = best_dist;
         r.attracted = (best_dist <= attract_thr);
         r.killed = kill_seen;
         nearest_due.push_back(r);
         best_dist = '0;
         best_index = '0;
         list_pos = 0;
         kill_seen = 1'b0;
      end
   endtask

   // hold the transaction while stalled, otherwise advance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) track_node(on_bus);
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (node_backlog.size() > 0) begin
               on_bus = node_backlog.pop_front();
               req_valid <= 1'b1;
               req_point_x <= on_bus.px;
               req_point_y <= on_bus.py;
               req_point_z <= on_bus.pz;
               req_node_x <= on_bus.nx;
               req_node_y <= on_bus.ny;
               req_node_z <= on_bus.nz;
               req_node_last <= on_bus.last;
               if (!calm && $urandom_range(0, 9) == 0) req_gap = $urandom_range(1, 9);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      nearest_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (nearest_due.size() == 0) begin
               $display("%0t: unexpected transaction, index %0d dist %0d", $time,
                        rsp_closest_index, rsp_closest_dist_sq);
               mismatches++;
            end else begin
               want = nearest_due.pop_front();
               if (rsp_closest_index !== want.index) begin
                  $display("%0t: closest_index expected %0d actual %0d", $time,
                           want.index, rsp_closest_index);
                  mismatches++;
               end
               if (rsp_closest_dist_sq !== want.dist_sq) begin
                  $display("%0t: closest_dist_sq expected %0d actual %0d", $time,
                           want.dist_sq, rsp_closest_dist_sq);
                  mismatches++;
               end
               if (rsp_attracted !== want.attracted) begin
                  $display("%0t: attracted expected %0b actual %0b", $time,
                           want.attracted, rsp_attracted);
                  mismatches++;
               end
               if (rsp_killed !== want.killed) begin
                  $display("%0t: killed expected %0b actual %0b", $time,
                           want.killed, rsp_killed);
                  mismatches++;
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            rsp_hold = $urandom_range(0, 8);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic node_item_type mk_node(input int px, input int py, input int pz,
                                             input int nx, input int ny, input int nz,
                                             input bit last);
      node_item_type it;
      it.px = CoordW'(px);
      it.py = CoordW'(py);
      it.pz = CoordW'(pz);
      it.nx = CoordW'(nx);
      it.ny = CoordW'(ny);
      it.nz = CoordW'(nz);
      it.last = last;
      return it;
   endfunction

   function automatic logic [DistW-1:0] rand_threshold(input int unsigned span);
      longint unsigned v;
      case ($urandom_range(0, 3))
         0: v = 0;
         1: v = DistMax;
         2: v = {$urandom, $urandom} % (DistMax + 1);
         default: v = $urandom_range(0, 3 * span * span);
      endcase
      return DistW'(v);
   endfunction

   task automatic queue_list(input int unsigned len, input int unsigned span,
                             input int zero_at);
      node_item_type it;
      node_item_type prev;
      int unsigned   k;
      it.px = CoordW'($urandom);
      it.py = CoordW'($urandom);
      it.pz = CoordW'($urandom);
      prev = it;
      for (k = 0; k < len; k++) begin
         if ($urandom_range(0, 15) == 0) begin
            it.px = CoordW'($urandom);
            it.py = CoordW'($urandom);
            it.pz = CoordW'($urandom);
         end
         case ($urandom_range(0, 3))
            0: begin
               it.nx = CoordW'($urandom);
               it.ny = CoordW'($urandom);
               it.nz = CoordW'($urandom);
            end
            3: begin
               it.nx = (k > 0) ? prev.nx : it.px;
               it.ny = (k > 0) ? prev.ny : it.py;
               it.nz = (k > 0) ? prev.nz : it.pz;
            end
            default: begin
               it.nx = it.px + CoordW'($urandom_range(0, 2 * span) - span);
               it.ny = it.py + CoordW'($urandom_range(0, 2 * span) - span);
               it.nz = it.pz + CoordW'($urandom_range(0, 2 * span) - span);
            end
         endcase
         if (zero_at >= 0 && k == zero_at) begin
            it.nx = it.px;
            it.ny = it.py;
            it.nz = it.pz;
         end
         it.last = (k == len - 1);
         node_backlog.push_back(it);
         prev = it;
      end
   endtask

   task automatic queue_lists(input int unsigned budget, input int unsigned span);
      int unsigned count;
      int unsigned len;
      count = 0;
      while (count < budget) begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
         queue_list(len, span, -1);
         count += len;
      end
   endtask

   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input logic [DistW-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_KILL_DIST_SQ) kill_thr = val;
      else if (idx == CSR_ATTRACT_DIST_SQ) attract_thr = val;
   endtask

   task automatic set_thresholds(input logic [DistW-1:0] kill, input logic [DistW-1:0] attract);
      write_csr(CSR_KILL_DIST_SQ, kill);
      write_csr(CSR_ATTRACT_DIST_SQ, attract);
   endtask

   // hold off until every list has come back and the pipeline has emptied
   task automatic wait_idle();
      do @(negedge clock);
      while (node_backlog.size() != 0 || req_valid || nearest_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      int unsigned p;
      int unsigned span;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // thresholds at their reset value of zero
      node_backlog.push_back(mk_node(0, 0, 0, 0, 0, 0, 1));
      node_backlog.push_back(mk_node(-32768, -32768, -32768, 32767, 32767, 32767, 1));
      node_backlog.push_back(mk_node(32767, 32767, 32767, -32768, -32768, -32768, 1));
      node_backlog.push_back(mk_node(100, -200, 300, 101, -200, 300, 0));
      node_backlog.push_back(mk_node(100, -200, 300, 100, -201, 300, 0));
      node_backlog.push_back(mk_node(100, -200, 300, 105, -200, 300, 1));
      node_backlog.push_back(mk_node(-5, 7, 0, -2, 7, 0, 0));
      node_backlog.push_back(mk_node(-5, 7, 0, -5, 9, 0, 0));
      node_backlog.push_back(mk_node(-5, 7, 0, -5, 7, 2, 1));
      node_backlog.push_back(mk_node(0, 0, 0, 10, 0, 0, 0));
      node_backlog.push_back(mk_node(10, 0, 0, 10, 0, 0, 1));
      node_backlog.push_back(mk_node(-1, -1, -1, -1, -1, 0, 0));
      node_backlog.push_back(mk_node(-1, -1, -1, 0, 0, -1, 1));
      wait_idle();

      set_thresholds(DistW'(DistMax), '0);
      queue_lists(120, 8);
      wait_idle();

      set_thresholds('0, DistW'(DistMax));
      queue_lists(120, 300);
      wait_idle();

      // long list: index saturates, zero distance found past the last position
      set_thresholds(rand_threshold(2000), rand_threshold(2000));
      queue_list(1030, 2000, 1026);
      wait_idle();

      for (p = 0; p < 5; p++) begin
         span = $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(17, 5000);
         set_thresholds(rand_threshold(span), rand_threshold(span));
         queue_lists(100, span);
         wait_idle();
      end

      calm = 1'b1;
      set_thresholds(rand_threshold(16), rand_threshold(16));
      queue_lists(100, 16);
      wait_idle();
      repeat (8) @(negedge clock);

      if (mismatches == 0 && nearest_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
design/nnkc_pkg.sv
design/nnkc_dist.sv
design/nnkc_track.sv
design/nearest_node_with_kill_check_unit.sv
bench/tb_nearest_node_with_kill_check_unit.sv
